>>> rtl/hmp_pkg.sv
// ============================================================================
// hmp_pkg
// Shared types and constants of the hash message padder: register indexes,
// controller states, byte sources and the command and status bundles.
// ============================================================================
`default_nettype none

package hmp_pkg;

    localparam int unsigned MAX_BLOCK_BYTES_DEF = 128;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_BYTES      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WORD_BYTES       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LENGTH_BYTES     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BIG_ENDIAN_ORDER = 3'd3;

    localparam logic [7:0] MARK_BYTE = 8'h80;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MARK,
        ST_ZERO,
        ST_LEN
    } state_t;

    typedef enum logic [1:0] {
        SRC_DATA,
        SRC_MARK,
        SRC_ZERO,
        SRC_LEN
    } byte_src_t;

    typedef struct packed {
        logic      push;
        byte_src_t sel;
        logic      count;
        logic      len_step;
        logic      finish;
    } cmd_t;

    typedef struct packed {
        logic slot_free;
        logic at_len_start;
        logic len_last;
    } status_t;

endpackage

`default_nettype wire

>>> rtl/hmp_ctrl.sv
// ============================================================================
// hmp_ctrl
// Sequencer: takes input transactions, then walks the marker, zero fill and
// length field one byte per cycle while the output slot is free, issuing push commands to the datapath.
// ============================================================================
`default_nettype none

module hmp_ctrl
    import hmp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire logic    byte_valid,
    input  wire logic    end_of_message,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd.push     = 1'b0;
        cmd.sel      = SRC_DATA;
        cmd.count    = 1'b0;
        cmd.len_step = 1'b0;
        cmd.finish   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = status.slot_free;
                if (in_valid && status.slot_free)
                begin
                    cmd.push  = byte_valid;
                    cmd.count = byte_valid;
                    if (end_of_message)
                    begin
                        state_next = ST_MARK;
                    end
                end
            end
            ST_MARK:
            begin
                if (status.slot_free)
                begin
                    cmd.push   = 1'b1;
                    cmd.sel    = SRC_MARK;
                    state_next = ST_ZERO;
                end
            end
            ST_ZERO:
            begin
                if (status.at_len_start)
                begin
                    state_next = ST_LEN;
                end
                else if (status.slot_free)
                begin
                    cmd.push = 1'b1;
                    cmd.sel  = SRC_ZERO;
                end
            end
            ST_LEN:
            begin
                if (status.slot_free)
                begin
                    cmd.push     = 1'b1;
                    cmd.sel      = SRC_LEN;
                    cmd.len_step = 1'b1;
                    if (status.len_last)
                    begin
                        cmd.finish = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/hmp_datapath.sv
// ============================================================================
// hmp_datapath
// Configuration registers, word packing, block position, byte count, length
// field byte selection and the output register.
// ============================================================================
`default_nettype none

module hmp_datapath
    import hmp_pkg::*;
#(
    parameter int unsigned MAX_BLOCK_BYTES = MAX_BLOCK_BYTES_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire cmd_t                   cmd,
    output status_t                     status,
    input  wire logic [7:0]             data_byte,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [63:0]                 padded_word,
    output logic                        block_end,
    output logic                        message_end
);

    localparam int unsigned BIB_W    = $clog2(MAX_BLOCK_BYTES);
    localparam int unsigned CNT_W    = BIB_W + 1;
    localparam logic        LARGE_OK = (MAX_BLOCK_BYTES >= 128);

    logic blk_large_reg;
    logic wrd8_reg;
    logic len16_reg;
    logic big_reg;

    logic [63:0]      acc_reg;
    logic [63:0]      acc_next;
    logic [BIB_W-1:0] bib_reg;
    logic [BIB_W-1:0] bib_next;
    logic [60:0]      total_reg;
    logic [60:0]      total_next;
    logic [3:0]       len_cnt_reg;
    logic [3:0]       len_cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [63:0]      word_reg;
    logic             block_end_reg;
    logic             message_end_reg;

    logic [CNT_W-1:0] blk_size;
    logic [CNT_W-1:0] len_size;
    logic [CNT_W-1:0] len_start;
    logic [CNT_W-1:0] bib_inc;
    logic             bend;
    logic [2:0]       pos;
    logic [2:0]       wtop;
    logic [2:0]       lane;
    logic             word_last;
    logic [3:0]       len_top;
    logic [3:0]       len_k;
    logic [7:0][7:0]  len_lanes;
    logic [7:0]       len_byte;
    logic [7:0]       push_val;
    logic [7:0][7:0]  acc_lanes;
    logic [7:0][7:0]  acc_or;
    logic             emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_large_reg <= 1'b0;
            wrd8_reg      <= 1'b0;
            len16_reg     <= 1'b0;
            big_reg       <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_BLOCK_BYTES:      blk_large_reg <= cfg_data[7];
                REG_WORD_BYTES:       wrd8_reg      <= cfg_data[3];
                REG_LENGTH_BYTES:     len16_reg     <= cfg_data[4];
                REG_BIG_ENDIAN_ORDER: big_reg       <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign blk_size  = (blk_large_reg && LARGE_OK) ? CNT_W'(128) : CNT_W'(64);
    assign len_size  = len16_reg ? CNT_W'(16) : CNT_W'(8);
    assign len_start = blk_size - len_size;

    assign pos       = wrd8_reg ? bib_reg[2:0] : {1'b0, bib_reg[1:0]};
    assign wtop      = wrd8_reg ? 3'd7 : 3'd3;
    assign word_last = (pos == wtop);
    assign lane      = big_reg ? (wtop - pos) : pos;
    assign bib_inc   = {1'b0, bib_reg} + CNT_W'(1);
    assign bend      = (bib_inc >= blk_size);

    assign len_top   = len16_reg ? 4'd15 : 4'd7;
    assign len_k     = big_reg ? (len_top - len_cnt_reg) : len_cnt_reg;
    assign len_lanes = {total_reg, 3'b000};
    assign len_byte  = len_k[3] ? 8'h00 : len_lanes[len_k[2:0]];

    always_comb
    begin
        unique case (cmd.sel)
            SRC_DATA: push_val = data_byte;
            SRC_MARK: push_val = MARK_BYTE;
            SRC_ZERO: push_val = 8'h00;
            SRC_LEN:  push_val = len_byte;
            default:  push_val = 8'h00;
        endcase
    end

    assign acc_lanes = acc_reg;

    always_comb
    begin
        for (int j = 0; j < 8; j++)
        begin
            acc_or[j] = acc_lanes[j] | ((lane == 3'(j)) ? push_val : 8'h00);
        end
    end

    always_comb
    begin
        acc_next     = acc_reg;
        bib_next     = bib_reg;
        total_next   = total_reg;
        len_cnt_next = len_cnt_reg;
        emit         = 1'b0;
        if (cmd.push)
        begin
            if (word_last)
            begin
                emit     = 1'b1;
                acc_next = '0;
                bib_next = bend ? '0 : bib_inc[BIB_W-1:0];
            end
            else
            begin
                acc_next = acc_or;
                bib_next = bib_inc[BIB_W-1:0];
            end
        end
        if (cmd.count)
        begin
            total_next = total_reg + 61'd1;
        end
        if (cmd.len_step)
        begin
            len_cnt_next = len_cnt_reg + 4'd1;
        end
        if (cmd.finish)
        begin
            acc_next     = '0;
            bib_next     = '0;
            total_next   = '0;
            len_cnt_next = '0;
        end
    end

    assign out_valid_next = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            bib_reg       <= '0;
            total_reg     <= '0;
            len_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            bib_reg       <= bib_next;
            total_reg     <= total_next;
            len_cnt_reg   <= len_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            word_reg        <= acc_or;
            block_end_reg   <= bend;
            message_end_reg <= cmd.finish;
        end
    end

    assign status.slot_free    = !out_valid_reg || out_ready;
    assign status.at_len_start = ({1'b0, bib_reg} == len_start);
    assign status.len_last     = (len_cnt_reg == (len_size[3:0] - 4'd1));

    assign out_valid   = out_valid_reg;
    assign padded_word = word_reg;
    assign block_end   = block_end_reg;
    assign message_end = message_end_reg;

    a_push_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> status.slot_free)
        else $error("push issued while output slot occupied");

    a_finish_closes_block: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> cmd.push && word_last && bend)
        else $error("length field does not end on a block boundary");

    a_finish_emits_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid && message_end && block_end)
        else $error("final word not flagged as message end");

    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (total_reg == '0) && (bib_reg == '0) && (acc_reg == '0))
        else $error("message state not cleared after padding");

endmodule

`default_nettype wire

>>> rtl/hash_message_padder_top.sv
// ============================================================================
// hash_message_padder_top
// Packs message bytes into words and appends the 0x80 marker, zero fill and
// bit length field, closing the padded message on a block boundary.
// ============================================================================
// Data bytes: one per cycle while the output drains; a word sits in the output
// register the cycle after its last byte is taken.
// End of message: one padding byte (marker, zeros, length field) per cycle plus
// an idle step at the start of the length field; input is held meanwhile. The
// single output register sets the pace: every byte waits for the slot. Reset
// clears all but the output word and flags; config resets to 64/4/8/little.
// ============================================================================
`default_nettype none

module hash_message_padder_top
    import hmp_pkg::*;
#(
    parameter int unsigned MAX_BLOCK_BYTES = MAX_BLOCK_BYTES_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [7:0]             data_byte,
    input  wire logic                   byte_valid,
    input  wire logic                   end_of_message,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [63:0]                 padded_word,
    output logic                        block_end,
    output logic                        message_end
);

    cmd_t    cmd;
    status_t status;

    hmp_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .byte_valid     (byte_valid),
        .end_of_message (end_of_message),
        .status         (status),
        .cmd            (cmd)
    );

    hmp_datapath #(
        .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .status      (status),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .padded_word (padded_word),
        .block_end   (block_end),
        .message_end (message_end)
    );

endmodule

`default_nettype wire

>>> tb/sv/hmp_padding_checker.sv
// ============================================================================
// hmp_padding_checker
// Watches the configuration port and both streams of the message padder. It
// rebuilds the padded words from every accepted input transaction and
// compares each output transaction, field by field, with the oldest word
// still expected.
// ============================================================================
module hmp_padding_checker
    import hmp_pkg::*;
#(
    parameter int unsigned MAX_BLOCK_BYTES = MAX_BLOCK_BYTES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic [7:0]             data_byte,
    input  logic                   byte_valid,
    input  logic                   end_of_message,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic [63:0]            padded_word,
    input  logic                   block_end,
    input  logic                   message_end,
    output int unsigned            fail_count,
    output int unsigned            pending_words,
    output int unsigned            words_checked,
    output int unsigned            messages_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [63:0] padded;
        logic        blk_end;
        logic        msg_end;
    } padded_word_t;

    padded_word_t expected_words[$];

    logic [63:0] word_acc;
    logic [6:0]  blk_pos;
    logic [60:0] msg_bytes;

    logic [7:0]  reg_block;
    logic [3:0]  reg_word;
    logic [4:0]  reg_len;
    logic        reg_big;

    function automatic int unsigned blk_bytes_cfg();
        return (reg_block[7] && MAX_BLOCK_BYTES >= 128) ? 128 : 64;
    endfunction

    function automatic int unsigned wrd_bytes_cfg();
        return reg_word[3] ? 8 : 4;
    endfunction

    function automatic int unsigned length_size();
        return reg_len[4] ? 16 : 8;
    endfunction

    task automatic pack_byte(input logic [7:0] b);
        int unsigned wb;
        int unsigned pos;
        int unsigned sh;
        int unsigned nxt;
        logic        bend;
        wb  = wrd_bytes_cfg();
        pos = blk_pos & (wb - 1);
        sh  = reg_big ? 8 * (wb - 1 - pos) : 8 * pos;
        word_acc = word_acc | (64'(b) << sh);
        nxt = blk_pos + 1;
        if (pos == wb - 1)
        begin
            bend = (nxt >= blk_bytes_cfg());
            expected_words.push_back('{padded: word_acc, blk_end: bend, msg_end: 1'b0});
            word_acc = '0;
            if (bend) nxt = 0;
        end
        blk_pos = 7'(nxt);
    endtask

    task automatic append_padding();
        int unsigned  lb;
        int unsigned  k;
        logic [63:0]  bit_count;
        padded_word_t last_word;
        lb = length_size();
        bit_count = {msg_bytes, 3'b000};
        pack_byte(MARK_BYTE);
        while (blk_pos != blk_bytes_cfg() - lb)
            pack_byte(8'h00);
        for (int unsigned i = 0; i < lb; i++)
        begin
            k = reg_big ? lb - 1 - i : i;
            pack_byte(k < 8 ? 8'(bit_count >> (8 * k)) : 8'h00);
        end
        last_word = expected_words.pop_back();
        last_word.msg_end = 1'b1;
        expected_words.push_back(last_word);
        word_acc  = '0;
        blk_pos   = '0;
        msg_bytes = '0;
    endtask

    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] got);
        if (want !== got)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        padded_word_t want;
        if (!rst_n)
        begin
            expected_words.delete();
            word_acc      = '0;
            blk_pos       = '0;
            msg_bytes     = '0;
            reg_block     = 8'd64;
            reg_word      = 4'd4;
            reg_len       = 5'd8;
            reg_big       = 1'b0;
            fail_count    = 0;
            pending_words = 0;
            words_checked = 0;
            messages_seen = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_BLOCK_BYTES:      reg_block = cfg_data[7:0];
                    REG_WORD_BYTES:       reg_word  = cfg_data[3:0];
                    REG_LENGTH_BYTES:     reg_len   = cfg_data[4:0];
                    REG_BIG_ENDIAN_ORDER: reg_big   = cfg_data[0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                if (byte_valid)
                begin
                    pack_byte(data_byte);
                    msg_bytes = msg_bytes + 1'b1;
                end
                if (end_of_message)
                begin
                    append_padding();
                    messages_seen++;
                end
            end
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected word, expected none, actual %h %s %b %s %b",
                             $time, padded_word, "block_end", block_end,
                             "message_end", message_end);
                end
                else
                begin
                    want = expected_words.pop_front();
                    compare_field("padded_word", want.padded, padded_word);
                    compare_field("block_end", 64'(want.blk_end), 64'(block_end));
                    compare_field("message_end", 64'(want.msg_end), 64'(message_end));
                    words_checked++;
                end
            end
            pending_words = expected_words.size();
        end
    end

endmodule

>>> tb/sv/tb_hash_message_padder_top.sv
// ============================================================================
// tb_hash_message_padder_top
// Drives message bytes and register settings into the padder, takes its words
// with random back-pressure and a long stall, and reports the checker verdict.
// ============================================================================
module tb_hash_message_padder_top
    import hmp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;

    localparam int unsigned CYCLE_LIMIT   = 500000;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned DRAIN_CYCLES  = 60;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned MAX_GAP       = 13;
    localparam int unsigned PHASES        = 4;
    localparam int unsigned PHASE_ITEMS   = 24;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic [7:0]             data_byte;
    logic                   byte_valid;
    logic                   end_of_message;
    logic                   out_valid;
    logic                   out_ready;
    logic [63:0]            padded_word;
    logic                   block_end;
    logic                   message_end;

    int unsigned fail_count;
    int unsigned pending_words;
    int unsigned words_checked;
    int unsigned messages_seen;

    int unsigned cycle_count = 0;
    int unsigned items_sent = 0;
    int unsigned settings_used = 0;
    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;
    logic [7:0]  cur_block = 8'd64;
    logic [7:0]  cur_len = 8'd8;

    hash_message_padder_top u_dut (.*);

    hmp_padding_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout at cycle %0d with %0d words still expected",
                     cycle_count, pending_words);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_item(input logic [7:0] d, input logic bv, input logic eom);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid       <= 1'b1;
        data_byte      <= d;
        byte_valid     <= bv;
        end_of_message <= eom;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_message(input int unsigned len, input bit finish_msg);
        bit eom_on_byte;
        eom_on_byte = finish_msg && len != 0 && $urandom_range(0, 1);
        for (int unsigned i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, eom_on_byte && i == len - 1);
            items_sent++;
        end
        if (finish_msg && !eom_on_byte)
        begin
            send_item(8'($urandom), 1'b0, 1'b1);
            items_sent++;
        end
    endtask

    function automatic int unsigned pick_length();
        int unsigned blk;
        int unsigned lb;
        blk = cur_block[7] ? 128 : 64;
        lb  = cur_len[4] ? 16 : 8;
        unique case ($urandom_range(0, 9))
            5:       return blk - lb - 1;
            6:       return blk - lb;
            7:       return blk;
            8:       return blk - 1;
            9:       return $urandom_range(0, blk + 20);
            default: return $urandom_range(0, 12);
        endcase
    endfunction

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
    endtask

    task automatic set_registers(input logic [7:0] blk_v, input logic [7:0] wrd_v,
                                 input logic [7:0] len_v, input logic [7:0] big_v);
        cfg_write(REG_BLOCK_BYTES, blk_v);
        cfg_write(REG_WORD_BYTES, wrd_v);
        cfg_write(REG_LENGTH_BYTES, len_v);
        cfg_write(REG_BIG_ENDIAN_ORDER, big_v);
        cfg_wr_en <= 1'b0;
        cur_block = blk_v;
        cur_len   = len_v;
        settings_used++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_words != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        int unsigned gap;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                gap = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            else
            begin
                gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (gap != 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial
    begin
        int unsigned phase_start;
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        data_byte      = '0;
        byte_valid     = 1'b0;
        end_of_message = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'($urandom), 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h5A, 1'b1, 1'b0);
        send_item(8'hA5, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        settle();

        cfg_write(REG_SPARE, 8'($urandom));
        set_registers(8'h80, 8'h08, 8'h10, 8'h01);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h12, 1'b1, 1'b0);
        send_item(8'h34, 1'b1, 1'b0);
        send_item(8'h56, 1'b1, 1'b0);
        send_item(8'($urandom), 1'b0, 1'b1);
        send_message(5, 1'b0);
        settle();

        // narrow the words and flip the byte order with five bytes pending
        set_registers(8'h80, 8'h04, 8'h10, 8'h00);
        send_message(2, 1'b1);
        settle();

        for (int unsigned p = 0; p < PHASES; p++)
        begin
            unique case (p)
                0:       set_registers(8'h80, 8'h08, 8'h10, 8'h00);
                1:       set_registers(8'h40, 8'h04, 8'h08, 8'h01);
                default: set_registers(8'($urandom), 8'($urandom), 8'($urandom),
                                       8'($urandom));
            endcase
            quiet = (p == 3);
            if (p == 2) hold_req = 1'b1;
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
                send_message(pick_length(), 1'b1);
            // leave a message open past the block shrink of the next phase; after the middle phases, only at random
            if (p == 0)
                send_message($urandom_range(70, 100), 1'b0);
            else if (p != PHASES - 1 && $urandom_range(0, 1) == 1)
                send_message($urandom_range(1, 40), 1'b0);
            settle();
        end

        quiet = 1'b1;
        in_valid <= 1'b0;
        while (pending_words != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Checked %0d words of %0d padded messages over %0d register settings,",
                 words_checked, messages_seen, settings_used);
        $display("including block shrink and word change mid-message and a long output stall.");
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/hmp_pkg.sv
rtl/hmp_ctrl.sv
rtl/hmp_datapath.sv
rtl/hash_message_padder_top.sv
tb/sv/hmp_padding_checker.sv
tb/sv/tb_hash_message_padder_top.sv
